@@ rtl/philox_counter_block_generator_core_assert.svh @@
// Assertion macros used by the Philox block generator RTL.
`ifndef PHILOX_COUNTER_BLOCK_GENERATOR_CORE_ASSERT_SVH
`define PHILOX_COUNTER_BLOCK_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCBG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pcbg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCBG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pcbg assertion failed");

`endif

@@ rtl/pcbg_pkg.sv @@
// Types and constants shared by the Philox block generator modules.
package pcbg_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned KEY_W     = 64;
    localparam int unsigned HALF_W    = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [WORD_W-1:0] MUL_A  = 32'hD2511F53;
    localparam logic [WORD_W-1:0] MUL_B  = 32'hCD9E8D57;
    localparam logic [WORD_W-1:0] WEYL_A = 32'h9E3779B9;
    localparam logic [WORD_W-1:0] WEYL_B = 32'hBB67AE85;

    localparam logic [CFG_IDX_W-1:0] REG_KEY          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STREAM_CLASS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENVIRONMENT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EPISODE      = 3'd4;

    typedef logic [3:0][WORD_W-1:0] t_block;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [HALF_W-1:0] stream_class;
        logic [HALF_W-1:0] channel;
        logic [WORD_W-1:0] environment;
        logic [WORD_W-1:0] episode;
    } t_cfg;

endpackage

@@ rtl/philox_counter_block_generator_core.sv @@
// Each round is a registered stage: an accepted request passes through the round registers in order
// and is on the output from the last one; a stall can hold it in any stage on the way.
// Throughput: one request per cycle unless stalled; each round is one pipeline stage with two 32x32 multipliers.
// Bubbles collapse, so a stalled output holds its result while earlier stages keep filling.
// Reset clears every stage valid bit and sets all configuration registers to zero.
// Configuration writes take effect at the next clock edge.
module philox_counter_block_generator_core
    import pcbg_pkg::*;
#(
    parameter int unsigned ROUNDS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [WORD_W-1:0]     i_draw_index,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [WORD_W-1:0]     o_word0,
    output logic [WORD_W-1:0]     o_word1,
    output logic [WORD_W-1:0]     o_word2,
    output logic [WORD_W-1:0]     o_word3
);

`include "philox_counter_block_generator_core_assert.svh"

    t_cfg              cfg;
    t_block            counter;
    t_block            stage_data  [ROUNDS];
    logic [ROUNDS-1:0] stage_valid;
    logic [ROUNDS-1:0] stage_ready;
    logic              in_acc;
    logic              out_acc;

    pcbg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    always_comb begin
        counter[0] = i_draw_index;
        counter[1] = cfg.episode;
        counter[2] = cfg.environment;
        counter[3] = {cfg.stream_class, cfg.channel};
    end

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        logic   up_valid;
        logic   down_ready;
        t_block up_data;

        if (g == 0) begin : g_first
            assign up_valid = i_valid;
            assign up_data  = counter;
        end else begin : g_rest
            assign up_valid = stage_valid[g-1];
            assign up_data  = stage_data[g-1];
        end

        if (g == ROUNDS - 1) begin : g_last
            assign down_ready = !i_stall;
        end else begin : g_mid
            assign down_ready = stage_ready[g+1];
        end

        pcbg_round #(
            .ROUND_IDX (g)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (up_valid),
            .o_ready (stage_ready[g]),
            .i_data  (up_data),
            .i_key   (cfg.key),
            .o_valid (stage_valid[g]),
            .i_ready (down_ready),
            .o_data  (stage_data[g])
        );
    end

    assign o_stall = !stage_ready[0];
    assign o_valid = stage_valid[ROUNDS-1];
    assign o_word0 = stage_data[ROUNDS-1][0];
    assign o_word1 = stage_data[ROUNDS-1][1];
    assign o_word2 = stage_data[ROUNDS-1][2];
    assign o_word3 = stage_data[ROUNDS-1][3];

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    // The input is held off only when every stage holds a request.
    `PCBG_ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, o_stall, &stage_valid)
    `PCBG_ASSERT_NEXT(a_occupancy_grows, i_clk, i_rst_n, in_acc && !out_acc,
        $countones(stage_valid) == $countones($past(stage_valid)) + 1)
    `PCBG_ASSERT_NEXT(a_occupancy_shrinks, i_clk, i_rst_n, out_acc && !in_acc,
        $countones(stage_valid) + 1 == $countones($past(stage_valid)))

endmodule

@@ rtl/pcbg_cfg.sv @@
// Configuration register file of the Philox block generator.
module pcbg_cfg
    import pcbg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KEY:          n_cfg.key          = i_cfg_data[KEY_W-1:0];
                REG_STREAM_CLASS: n_cfg.stream_class = i_cfg_data[HALF_W-1:0];
                REG_CHANNEL:      n_cfg.channel      = i_cfg_data[HALF_W-1:0];
                REG_ENVIRONMENT:  n_cfg.environment  = i_cfg_data[WORD_W-1:0];
                REG_EPISODE:      n_cfg.episode      = i_cfg_data[WORD_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/pcbg_round.sv @@
// One Philox round followed by its pipeline register and handshake slot.
module pcbg_round
    import pcbg_pkg::*;
#(
    parameter int unsigned ROUND_IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_block           i_data,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_valid,
    input  logic             i_ready,
    output t_block           o_data
);

    localparam logic [63:0] OFS_A = 64'(ROUND_IDX) * {32'd0, WEYL_A};
    localparam logic [63:0] OFS_B = 64'(ROUND_IDX) * {32'd0, WEYL_B};

    logic [WORD_W-1:0] ka;
    logic [WORD_W-1:0] kb;
    logic [63:0]       pa;
    logic [63:0]       pb;
    t_block            n_data;
    t_block            r_data;
    logic              r_valid;

    assign ka = i_key[WORD_W-1:0] + OFS_A[WORD_W-1:0];
    assign kb = i_key[KEY_W-1:WORD_W] + OFS_B[WORD_W-1:0];
    assign pa = {32'd0, MUL_A} * {32'd0, i_data[0]};
    assign pb = {32'd0, MUL_B} * {32'd0, i_data[2]};

    always_comb begin
        n_data[0] = pb[63:32] ^ i_data[1] ^ ka;
        n_data[1] = pb[31:0];
        n_data[2] = pa[63:32] ^ i_data[3] ^ kb;
        n_data[3] = pa[31:0];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
